>>> hw/rtl/fwmt_pkg.sv
// ----------------------------------------------------------------------------
// fwmt_pkg
// Types and constants shared by the flash window mailbox tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fwmt_pkg;

  localparam logic [1:0] CMD_ISSUE  = 2'd0;
  localparam logic [1:0] CMD_RESP   = 2'd1;
  localparam logic [1:0] CMD_ATTN   = 2'd2;
  localparam logic [1:0] CMD_XLATE  = 2'd3;

  localparam logic [3:0] CODE_RESET     = 4'd0;
  localparam logic [3:0] CODE_MBOXINFO  = 4'd1;
  localparam logic [3:0] CODE_FLASHINFO = 4'd2;
  localparam logic [3:0] CODE_READWIN   = 4'd3;
  localparam logic [3:0] CODE_CLOSE     = 4'd4;
  localparam logic [3:0] CODE_WRITEWIN  = 4'd5;
  localparam logic [3:0] CODE_DIRTY     = 4'd6;
  localparam logic [3:0] CODE_FLUSH     = 4'd7;
  localparam logic [3:0] CODE_ACK       = 4'd8;
  localparam logic [3:0] CODE_ERASED    = 4'd9;

  localparam logic [7:0] RESP_SUCCESS   = 8'd1;
  localparam logic [4:0] DEFAULT_SHIFT  = 5'd12;
  localparam logic [4:0] MAX_SHIFT      = 5'd31;
  localparam logic [7:0] VERSION_ONE_ID = 8'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PERR     = 3'd1;
  localparam logic [2:0] ST_SEQ      = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_PAUSED   = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  code;
    logic        resp_ok;
    logic [7:0]  rcode;
    logic [7:0]  rseq;
    logic [63:0] args;
    logic        close_win;
    logic        pause;
    logic        sel;
    logic [31:0] pos;
    logic [31:0] len;
    logic [32:0] aend;
  } op_t;

  typedef struct packed {
    logic [7:0]  issued_seq;
    logic [2:0]  status;
    logic [7:0]  partner_error;
    logic        window_hit;
    logic [31:0] lpc_offset;
    logic [31:0] chunk_size;
    logic        paused_flag;
    logic        legacy_mode;
    logic [31:0] flash_total;
    logic [31:0] erase_size;
  } res_t;

  function automatic logic [31:0] to_bytes(input logic [15:0] blocks,
                                           input logic [4:0] shift);
    to_bytes = {16'd0, blocks} << shift;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fwmt_front.sv
// ----------------------------------------------------------------------------
// fwmt_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fwmt_front import fwmt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_command_code,
  input  wire logic [7:0]  in_response_code,
  input  wire logic [7:0]  in_response_seq,
  input  wire logic [63:0] in_response_args,
  input  wire logic [7:0]  in_attention_bits,
  input  wire logic        in_window_select,
  input  wire logic [31:0] in_access_position,
  input  wire logic [31:0] in_access_length,
  input  wire logic        take,
  output logic             op_valid,
  output op_t              op
);

  op_t        mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;
  op_t        cls;

  always_comb begin
    cls.cmd       = in_cmd;
    cls.code      = in_command_code;
    cls.resp_ok   = (in_response_code == RESP_SUCCESS);
    cls.rcode     = in_response_code;
    cls.rseq      = in_response_seq;
    cls.args      = in_response_args;
    cls.close_win = |in_attention_bits[1:0];
    cls.pause     = in_attention_bits[6];
    cls.sel       = in_window_select;
    cls.pos       = in_access_position;
    cls.len       = in_access_length;
    cls.aend      = {1'b0, in_access_position} + {1'b0, in_access_length};
  end

  assign in_full  = (count_r == 2'd2);
  assign op_valid = (count_r != 2'd0);
  assign op       = mem_r[rd_ptr_r];
  assign push     = in_push && !in_full;
  assign pop      = take && op_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fwmt_back.sv
// ----------------------------------------------------------------------------
// fwmt_back
// Holds protocol state; does one classified item per cycle while res_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fwmt_back import fwmt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic op_valid,
  input  wire op_t  op,
  input  wire logic res_ready,
  output logic      take,
  output logic      res_push,
  output res_t      res
);

  logic [31:0] rd_base_r, rd_span_r, rd_origin_r;
  logic [31:0] wr_base_r, wr_span_r, wr_origin_r;
  logic        rd_open_r, wr_open_r, pause_r, v1_r;
  logic [4:0]  shift_r;
  logic [7:0]  seq_r;
  logic [31:0] total_r, granule_r;

  logic [31:0] rd_base_nxt, rd_span_nxt, rd_origin_nxt;
  logic [31:0] wr_base_nxt, wr_span_nxt, wr_origin_nxt;
  logic        rd_open_nxt, wr_open_nxt, pause_nxt, v1_nxt;
  logic [4:0]  shift_nxt;
  logic [7:0]  seq_nxt;
  logic [31:0] total_nxt, granule_nxt;

  logic [2:0]  status;
  logic [7:0]  perr;
  logic        hit;
  logic [31:0] off;
  logic [31:0] chunk;
  logic [31:0] w_base, w_span, w_org;
  logic        w_open;
  logic [32:0] wend;
  logic [32:0] wrem;
  logic [31:0] a16_0, a16_1, a16_2, a16_3, a16_4;

  assign take     = op_valid && res_ready;
  assign res_push = take;

  assign a16_0 = to_bytes(op.args[15:0],  shift_r);
  assign a16_1 = to_bytes(op.args[23:8],  shift_r);
  assign a16_2 = to_bytes(op.args[31:16], shift_r);
  assign a16_3 = to_bytes(op.args[39:24], shift_r);
  assign a16_4 = to_bytes(op.args[47:32], shift_r);

  assign w_base = op.sel ? wr_base_r   : rd_base_r;
  assign w_span = op.sel ? wr_span_r   : rd_span_r;
  assign w_org  = op.sel ? wr_origin_r : rd_origin_r;
  assign w_open = op.sel ? wr_open_r   : rd_open_r;
  assign wend   = {1'b0, w_org} + {1'b0, w_span};
  assign wrem   = wend - {1'b0, op.pos};

  always_comb begin
    rd_base_nxt   = rd_base_r;
    rd_span_nxt   = rd_span_r;
    rd_origin_nxt = rd_origin_r;
    rd_open_nxt   = rd_open_r;
    wr_base_nxt   = wr_base_r;
    wr_span_nxt   = wr_span_r;
    wr_origin_nxt = wr_origin_r;
    wr_open_nxt   = wr_open_r;
    pause_nxt     = pause_r;
    v1_nxt        = v1_r;
    shift_nxt     = shift_r;
    seq_nxt       = seq_r;
    total_nxt     = total_r;
    granule_nxt   = granule_r;
    status        = ST_OK;
    perr          = 8'd0;
    hit           = 1'b0;
    off           = 32'd0;
    chunk         = 32'd0;
    case (op.cmd)
      CMD_ISSUE: begin
        seq_nxt = seq_r + 8'd1;
      end
      CMD_RESP: begin
        if (!op.resp_ok) begin
          status = ST_PERR;
          perr   = op.rcode;
        end else if (op.rseq != seq_r) begin
          status = ST_SEQ;
        end else if (v1_r) begin
          case (op.code)
            CODE_RESET, CODE_CLOSE, CODE_DIRTY, CODE_FLUSH, CODE_ACK: begin
              status = ST_OK;
            end
            CODE_MBOXINFO: begin
              rd_span_nxt = a16_1;
              wr_span_nxt = a16_3;
            end
            CODE_FLASHINFO: begin
              total_nxt   = op.args[31:0];
              granule_nxt = op.args[63:32];
            end
            CODE_READWIN: begin
              rd_base_nxt = a16_0;
              rd_open_nxt = 1'b1;
              wr_open_nxt = 1'b0;
            end
            CODE_WRITEWIN: begin
              wr_base_nxt = a16_0;
              wr_open_nxt = 1'b1;
              rd_open_nxt = 1'b0;
            end
            default: begin
              status = ST_UNKNOWN;
            end
          endcase
        end else begin
          case (op.code)
            CODE_RESET, CODE_DIRTY, CODE_FLUSH, CODE_ACK, CODE_ERASED: begin
              status = ST_OK;
            end
            CODE_MBOXINFO: begin
              if (op.args[7:0] == VERSION_ONE_ID) begin
                v1_nxt      = 1'b1;
                shift_nxt   = DEFAULT_SHIFT;
                rd_span_nxt = to_bytes(op.args[23:8], DEFAULT_SHIFT);
                wr_span_nxt = to_bytes(op.args[39:24], DEFAULT_SHIFT);
              end else if (op.args[47:40] > {3'd0, MAX_SHIFT}) begin
                shift_nxt = MAX_SHIFT;
              end else begin
                shift_nxt = op.args[44:40];
              end
            end
            CODE_FLASHINFO: begin
              total_nxt   = a16_0;
              granule_nxt = a16_2;
            end
            CODE_READWIN: begin
              rd_base_nxt   = a16_0;
              rd_span_nxt   = a16_2;
              rd_origin_nxt = a16_4;
              rd_open_nxt   = 1'b1;
              wr_open_nxt   = 1'b0;
            end
            CODE_CLOSE: begin
              rd_open_nxt = 1'b0;
              wr_open_nxt = 1'b0;
            end
            CODE_WRITEWIN: begin
              wr_base_nxt   = a16_0;
              wr_span_nxt   = a16_2;
              wr_origin_nxt = a16_4;
              wr_open_nxt   = 1'b1;
              rd_open_nxt   = 1'b0;
            end
            default: begin
              status = ST_UNKNOWN;
            end
          endcase
        end
      end
      CMD_ATTN: begin
        if (op.close_win) begin
          rd_open_nxt = 1'b0;
          wr_open_nxt = 1'b0;
        end
        pause_nxt = op.pause;
      end
      default: begin
        off = w_base + (op.pos - w_org);
        if (op.aend <= wend) begin
          chunk = op.len;
        end else if ({1'b0, op.pos} <= wend) begin
          chunk = wrem[31:0];
        end else begin
          chunk = 32'd0;
        end
        hit = w_open && (op.pos >= w_org) && (op.aend <= wend);
        if (pause_r) begin
          status = ST_PAUSED;
        end else if (!hit) begin
          status = ST_MISS;
        end
      end
    endcase
  end

  always_comb begin
    res.issued_seq    = seq_nxt;
    res.status        = status;
    res.partner_error = perr;
    res.window_hit    = hit;
    res.lpc_offset    = off;
    res.chunk_size    = chunk;
    res.paused_flag   = pause_nxt;
    res.legacy_mode   = v1_nxt;
    res.flash_total   = total_nxt;
    res.erase_size    = granule_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_base_r   <= 32'd0;
      rd_span_r   <= 32'd0;
      rd_origin_r <= 32'd0;
      rd_open_r   <= 1'b0;
      wr_base_r   <= 32'd0;
      wr_span_r   <= 32'd0;
      wr_origin_r <= 32'd0;
      wr_open_r   <= 1'b0;
      pause_r     <= 1'b0;
      v1_r        <= 1'b0;
      shift_r     <= DEFAULT_SHIFT;
      seq_r       <= 8'd0;
      total_r     <= 32'd0;
      granule_r   <= 32'd0;
    end else if (take) begin
      rd_base_r   <= rd_base_nxt;
      rd_span_r   <= rd_span_nxt;
      rd_origin_r <= rd_origin_nxt;
      rd_open_r   <= rd_open_nxt;
      wr_base_r   <= wr_base_nxt;
      wr_span_r   <= wr_span_nxt;
      wr_origin_r <= wr_origin_nxt;
      wr_open_r   <= wr_open_nxt;
      pause_r     <= pause_nxt;
      v1_r        <= v1_nxt;
      shift_r     <= shift_nxt;
      seq_r       <= seq_nxt;
      total_r     <= total_nxt;
      granule_r   <= granule_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fwmt_result_q.sv
// ----------------------------------------------------------------------------
// fwmt_result_q
// Two-entry queue that holds finished results until they are popped.
// ----------------------------------------------------------------------------
`default_nettype none

module fwmt_result_q import fwmt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_res,
  output logic      ready,
  input  wire logic pop,
  output logic      empty,
  output res_t      head
);

  res_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign ready   = (count_r != 2'd2);
  assign empty   = (count_r == 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/flash_window_mailbox_tracker_top.sv
// ----------------------------------------------------------------------------
// flash_window_mailbox_tracker_top
// Client-side tracker for a mailbox flash-window protocol.
//
// Items enter through a queue-style port: an item is taken on a clock edge
// with in_push high and in_full low. Each item gives exactly one result,
// shown on the out_ ports while out_empty is low and removed by out_pop.
// An item first waits in a two-entry input queue, is executed by the state
// unit and lands in a two-entry result queue, whose head drives the out_
// ports. One item per cycle is sustained as long as results are popped at
// the same rate; the single state unit works out each result combinationally
// from its registered state.
// When the receiver stalls, the result queue fills, the state unit waits,
// and in_full rises once the input queue holds two items.
// Reset empties both queues, closes both windows, clears the sequence
// number, sizes and pause mark, selects version two rules and sets the
// block shift to twelve.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_window_mailbox_tracker_top import fwmt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_command_code,
  input  wire logic [7:0]  in_response_code,
  input  wire logic [7:0]  in_response_seq,
  input  wire logic [63:0] in_response_args,
  input  wire logic [7:0]  in_attention_bits,
  input  wire logic        in_window_select,
  input  wire logic [31:0] in_access_position,
  input  wire logic [31:0] in_access_length,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_issued_seq,
  output logic [2:0]       out_status,
  output logic [7:0]       out_partner_error,
  output logic             out_window_hit,
  output logic [31:0]      out_lpc_offset,
  output logic [31:0]      out_chunk_size,
  output logic             out_paused_flag,
  output logic             out_legacy_mode,
  output logic [31:0]      out_flash_total,
  output logic [31:0]      out_erase_size
);

  op_t  op;
  logic op_valid;
  logic take;
  logic res_ready;
  logic res_push;
  res_t res;
  res_t head;

  fwmt_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_cmd             (in_cmd),
    .in_command_code    (in_command_code),
    .in_response_code   (in_response_code),
    .in_response_seq    (in_response_seq),
    .in_response_args   (in_response_args),
    .in_attention_bits  (in_attention_bits),
    .in_window_select   (in_window_select),
    .in_access_position (in_access_position),
    .in_access_length   (in_access_length),
    .take               (take),
    .op_valid           (op_valid),
    .op                 (op)
  );

  fwmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op        (op),
    .res_ready (res_ready),
    .take      (take),
    .res_push  (res_push),
    .res       (res)
  );

  fwmt_result_q u_result_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_res (res),
    .ready    (res_ready),
    .pop      (out_pop),
    .empty    (out_empty),
    .head     (head)
  );

  assign out_issued_seq    = head.issued_seq;
  assign out_status        = head.status;
  assign out_partner_error = head.partner_error;
  assign out_window_hit    = head.window_hit;
  assign out_lpc_offset    = head.lpc_offset;
  assign out_chunk_size    = head.chunk_size;
  assign out_paused_flag   = head.paused_flag;
  assign out_legacy_mode   = head.legacy_mode;
  assign out_flash_total   = head.flash_total;
  assign out_erase_size    = head.erase_size;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_perr_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_PERR) |-> out_partner_error != RESP_SUCCESS)
    else $error("partner error reported with a success code");

  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_window_hit) |-> (out_status == ST_OK || out_status == ST_PAUSED))
    else $error("window hit with a miss or response status");

  a_issue_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && op.cmd == CMD_ISSUE) |-> res.issued_seq == u_back.seq_r + 8'd1)
    else $error("issued sequence did not advance by one");

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for flash_window_mailbox_tracker_top.
//
// Items are pushed through the queue-style input port with random gaps, and
// results are popped with random stalls. A scoreboard keeps its own copy of
// the tracker state, predicts one result per accepted item, and compares
// every popped result with the oldest prediction. A short directed part
// covers the corner cases. It is followed by random requests, responses,
// attention bits and translations, first under version-two rules and then
// under version-one rules.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fwmt_pkg::*;

  localparam logic [3:0] CODE_FIRST_UNKNOWN = CODE_ERASED + 4'd1;
  localparam logic [3:0] CODE_LAST          = 4'hf;
  localparam logic [7:0] ATTN_CLOSE_MASK    = 8'h03;
  localparam int         ATTN_FLASH_LOST    = 6;
  localparam logic [7:0] ATTN_DAEMON_READY  = 8'h80;
  localparam int RANDOM_ITEMS  = 800;
  localparam int LEGACY_SWITCH = 450;
  localparam int QUIET_TAIL    = 150;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  code;
    logic [7:0]  rcode;
    logic [7:0]  rseq;
    logic [63:0] args;
    logic [7:0]  attn;
    logic        sel;
    logic [31:0] pos;
    logic [31:0] len;
  } mbox_item_t;

  class mailbox_scoreboard;
    logic [31:0] rd_base, rd_span, rd_org, wr_base, wr_span, wr_org;
    logic        rd_open, wr_open, paused, legacy;
    logic [4:0]  shift;
    logic [7:0]  seq;
    logic [31:0] flash_bytes, erase_bytes;
    res_t        reports_due[$];
    int          error_count;

    function new();
      rd_base = '0;
      rd_span = '0;
      rd_org = '0;
      wr_base = '0;
      wr_span = '0;
      wr_org = '0;
      rd_open = 1'b0;
      wr_open = 1'b0;
      paused = 1'b0;
      legacy = 1'b0;
      shift = DEFAULT_SHIFT;
      seq = '0;
      flash_bytes = '0;
      erase_bytes = '0;
      error_count = 0;
    endfunction

    function logic [31:0] scale_blocks(logic [15:0] blocks);
      return {16'd0, blocks} << shift;
    endfunction

    function logic [2:0] apply_v2(logic [3:0] code, logic [63:0] a);
      case (code)
        CODE_RESET, CODE_DIRTY, CODE_FLUSH, CODE_ACK, CODE_ERASED: return ST_OK;
        CODE_MBOXINFO: begin
          if (a[7:0] == VERSION_ONE_ID) begin
            legacy = 1'b1;
            shift = DEFAULT_SHIFT;
            rd_span = scale_blocks(a[23:8]);
            wr_span = scale_blocks(a[39:24]);
          end else begin
            shift = (a[47:40] > {3'd0, MAX_SHIFT}) ? MAX_SHIFT : a[44:40];
          end
          return ST_OK;
        end
        CODE_FLASHINFO: begin
          flash_bytes = scale_blocks(a[15:0]);
          erase_bytes = scale_blocks(a[31:16]);
          return ST_OK;
        end
        CODE_READWIN: begin
          rd_base = scale_blocks(a[15:0]);
          rd_span = scale_blocks(a[31:16]);
          rd_org = scale_blocks(a[47:32]);
          rd_open = 1'b1;
          wr_open = 1'b0;
          return ST_OK;
        end
        CODE_CLOSE: begin
          rd_open = 1'b0;
          wr_open = 1'b0;
          return ST_OK;
        end
        CODE_WRITEWIN: begin
          wr_base = scale_blocks(a[15:0]);
          wr_span = scale_blocks(a[31:16]);
          wr_org = scale_blocks(a[47:32]);
          wr_open = 1'b1;
          rd_open = 1'b0;
          return ST_OK;
        end
        default: return ST_UNKNOWN;
      endcase
    endfunction

    function logic [2:0] apply_v1(logic [3:0] code, logic [63:0] a);
      case (code)
        CODE_RESET, CODE_CLOSE, CODE_DIRTY, CODE_FLUSH, CODE_ACK: return ST_OK;
        CODE_MBOXINFO: begin
          rd_span = scale_blocks(a[23:8]);
          wr_span = scale_blocks(a[39:24]);
          return ST_OK;
        end
        CODE_FLASHINFO: begin
          flash_bytes = a[31:0];
          erase_bytes = a[63:32];
          return ST_OK;
        end
        CODE_READWIN: begin
          rd_base = scale_blocks(a[15:0]);
          rd_open = 1'b1;
          wr_open = 1'b0;
          return ST_OK;
        end
        CODE_WRITEWIN: begin
          wr_base = scale_blocks(a[15:0]);
          wr_open = 1'b1;
          rd_open = 1'b0;
          return ST_OK;
        end
        default: return ST_UNKNOWN;
      endcase
    endfunction

    function void take_item(mbox_item_t it);
      res_t        r;
      logic [31:0] base, span, org;
      logic        open;
      logic [32:0] wend, aend;
      r = '0;
      case (it.cmd)
        CMD_ISSUE: seq = seq + 8'd1;
        CMD_RESP: begin
          if (it.rcode != RESP_SUCCESS) begin
            r.status = ST_PERR;
            r.partner_error = it.rcode;
          end else if (it.rseq != seq) begin
            r.status = ST_SEQ;
          end else if (legacy) begin
            r.status = apply_v1(it.code, it.args);
          end else begin
            r.status = apply_v2(it.code, it.args);
          end
        end
        CMD_ATTN: begin
          if ((it.attn & ATTN_CLOSE_MASK) != 8'd0) begin
            rd_open = 1'b0;
            wr_open = 1'b0;
          end
          paused = it.attn[ATTN_FLASH_LOST];
        end
        default: begin
          base = it.sel ? wr_base : rd_base;
          span = it.sel ? wr_span : rd_span;
          org = it.sel ? wr_org : rd_org;
          open = it.sel ? wr_open : rd_open;
          wend = {1'b0, org} + {1'b0, span};
          aend = {1'b0, it.pos} + {1'b0, it.len};
          r.lpc_offset = base + (it.pos - org);
          if (aend <= wend) begin
            r.chunk_size = it.len;
          end else if ({1'b0, it.pos} <= wend) begin
            r.chunk_size = wend[31:0] - it.pos;
          end else begin
            r.chunk_size = '0;
          end
          r.window_hit = open && (it.pos >= org) && (aend <= wend);
          if (paused) begin
            r.status = ST_PAUSED;
          end else if (!r.window_hit) begin
            r.status = ST_MISS;
          end else begin
            r.status = ST_OK;
          end
        end
      endcase
      r.issued_seq = seq;
      r.paused_flag = paused;
      r.legacy_mode = legacy;
      r.flash_total = flash_bytes;
      r.erase_size = erase_bytes;
      reports_due.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        error_count++;
      end
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (reports_due.size() == 0) begin
        $error("result popped with no item outstanding");
        error_count++;
        return;
      end
      want = reports_due.pop_front();
      check_field("issued_seq", want.issued_seq, got.issued_seq);
      check_field("status", want.status, got.status);
      check_field("partner_error", want.partner_error, got.partner_error);
      check_field("window_hit", want.window_hit, got.window_hit);
      check_field("lpc_offset", want.lpc_offset, got.lpc_offset);
      check_field("chunk_size", want.chunk_size, got.chunk_size);
      check_field("paused_flag", want.paused_flag, got.paused_flag);
      check_field("legacy_mode", want.legacy_mode, got.legacy_mode);
      check_field("flash_total", want.flash_total, got.flash_total);
      check_field("erase_size", want.erase_size, got.erase_size);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_cmd;
  logic [3:0]  in_command_code;
  logic [7:0]  in_response_code;
  logic [7:0]  in_response_seq;
  logic [63:0] in_response_args;
  logic [7:0]  in_attention_bits;
  logic        in_window_select;
  logic [31:0] in_access_position;
  logic [31:0] in_access_length;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_issued_seq;
  logic [2:0]  out_status;
  logic [7:0]  out_partner_error;
  logic        out_window_hit;
  logic [31:0] out_lpc_offset;
  logic [31:0] out_chunk_size;
  logic        out_paused_flag;
  logic        out_legacy_mode;
  logic [31:0] out_flash_total;
  logic [31:0] out_erase_size;

  mailbox_scoreboard sb = new();
  logic [7:0] seq_shadow = '0;
  bit         no_idle = 1'b0;

  flash_window_mailbox_tracker_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_cmd             (in_cmd),
    .in_command_code    (in_command_code),
    .in_response_code   (in_response_code),
    .in_response_seq    (in_response_seq),
    .in_response_args   (in_response_args),
    .in_attention_bits  (in_attention_bits),
    .in_window_select   (in_window_select),
    .in_access_position (in_access_position),
    .in_access_length   (in_access_length),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_issued_seq     (out_issued_seq),
    .out_status         (out_status),
    .out_partner_error  (out_partner_error),
    .out_window_hit     (out_window_hit),
    .out_lpc_offset     (out_lpc_offset),
    .out_chunk_size     (out_chunk_size),
    .out_paused_flag    (out_paused_flag),
    .out_legacy_mode    (out_legacy_mode),
    .out_flash_total    (out_flash_total),
    .out_erase_size     (out_erase_size)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin : monitor
    mbox_item_t taken;
    res_t       seen;
    if (rst_n && in_push && !in_full) begin
      taken.cmd = in_cmd;
      taken.code = in_command_code;
      taken.rcode = in_response_code;
      taken.rseq = in_response_seq;
      taken.args = in_response_args;
      taken.attn = in_attention_bits;
      taken.sel = in_window_select;
      taken.pos = in_access_position;
      taken.len = in_access_length;
      sb.take_item(taken);
    end
    if (rst_n && out_pop && !out_empty) begin
      seen.issued_seq = out_issued_seq;
      seen.status = out_status;
      seen.partner_error = out_partner_error;
      seen.window_hit = out_window_hit;
      seen.lpc_offset = out_lpc_offset;
      seen.chunk_size = out_chunk_size;
      seen.paused_flag = out_paused_flag;
      seen.legacy_mode = out_legacy_mode;
      seen.flash_total = out_flash_total;
      seen.erase_size = out_erase_size;
      sb.check_report(seen);
    end
  end

  function automatic logic [63:0] rand_args();
    return {$urandom, $urandom};
  endfunction

  function automatic mbox_item_t noise_item();
    mbox_item_t  it;
    logic [31:0] r;
    r = $urandom;
    it.cmd = r[1:0];
    it.code = r[5:2];
    it.rcode = r[13:6];
    it.rseq = r[21:14];
    it.attn = r[29:22];
    it.sel = r[30];
    it.args = rand_args();
    it.pos = $urandom;
    it.len = $urandom;
    return it;
  endfunction

  function automatic mbox_item_t issue_item();
    mbox_item_t it;
    it = noise_item();
    it.cmd = CMD_ISSUE;
    return it;
  endfunction

  function automatic mbox_item_t resp_item(logic [3:0] code, logic [7:0] rcode,
                                           logic [7:0] rseq, logic [63:0] args);
    mbox_item_t it;
    it = noise_item();
    it.cmd = CMD_RESP;
    it.code = code;
    it.rcode = rcode;
    it.rseq = rseq;
    it.args = args;
    return it;
  endfunction

  function automatic mbox_item_t attn_item(logic [7:0] bits);
    mbox_item_t it;
    it = noise_item();
    it.cmd = CMD_ATTN;
    it.attn = bits;
    return it;
  endfunction

  function automatic mbox_item_t xlate_item(logic sel, logic [31:0] pos, logic [31:0] len);
    mbox_item_t it;
    it = noise_item();
    it.cmd = CMD_XLATE;
    it.sel = sel;
    it.pos = pos;
    it.len = len;
    return it;
  endfunction

  function automatic logic [63:0] win_args(logic [15:0] base, logic [15:0] span,
                                           logic [15:0] org);
    logic [63:0] a;
    a = rand_args();
    a[47:0] = {org, span, base};
    return a;
  endfunction

  // Keeps byte 0 away from the version-one marker so that version-two rules stay.
  function automatic logic [63:0] shift_args(logic [7:0] shift_field);
    logic [63:0] a;
    a = rand_args();
    a[47:40] = shift_field;
    if (a[7:0] == VERSION_ONE_ID) a[1] = 1'b1;
    return a;
  endfunction

  function automatic mbox_item_t random_item(bit legacy_phase);
    mbox_item_t  it;
    int          pick;
    logic [31:0] r;
    it = noise_item();
    pick = $urandom_range(0, 99);
    r = $urandom;
    if (pick < 20) begin
      it.cmd = CMD_ISSUE;
    end else if (pick < 65) begin
      it.cmd = CMD_RESP;
      if ($urandom_range(0, 9) != 0) it.rcode = RESP_SUCCESS;
      if ($urandom_range(0, 9) != 0) it.rseq = seq_shadow;
      if ($urandom_range(0, 7) != 0) begin
        r = $urandom_range(CODE_RESET, CODE_ERASED);
        it.code = r[3:0];
      end
      r = $urandom;
      case (it.code)
        CODE_READWIN, CODE_WRITEWIN: begin
          if ($urandom_range(0, 4) != 0) begin
            it.args = win_args(r[15:0], {12'd0, r[19:16]} + 16'd1, {12'd0, r[23:20]});
          end
        end
        CODE_MBOXINFO: begin
          if (!legacy_phase) begin
            it.args = shift_args(($urandom_range(0, 3) != 0) ? 8'd12 : r[7:0]);
          end else if ($urandom_range(0, 3) != 0) begin
            it.args[39:8] = {12'd0, r[3:0], 12'd0, r[7:4]};
          end
        end
        default: ;
      endcase
    end else if (pick < 73) begin
      it.cmd = CMD_ATTN;
      if ($urandom_range(0, 3) != 0) it.attn[ATTN_FLASH_LOST] = 1'b0;
    end else begin
      it.cmd = CMD_XLATE;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        it.pos = $urandom_range(0, 32'h0002_0000);
        it.len = $urandom_range(0, 32'h0000_8000);
      end else if (pick < 85) begin
        it.pos = 32'hffff_ffff - $urandom_range(0, 32'h0000_ffff);
      end
    end
    return it;
  endfunction

  task automatic send_item(mbox_item_t it);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_cmd <= it.cmd;
    in_command_code <= it.code;
    in_response_code <= it.rcode;
    in_response_seq <= it.rseq;
    in_response_args <= it.args;
    in_attention_bits <= it.attn;
    in_window_select <= it.sel;
    in_access_position <= it.pos;
    in_access_length <= it.len;
    if (it.cmd == CMD_ISSUE) seq_shadow = seq_shadow + 8'd1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  initial begin
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [3:0]  odd_codes[4];
    logic [63:0] a;
    int          n;
    odd_codes = '{CODE_ERASED, CODE_FIRST_UNKNOWN, CODE_LAST, CODE_CLOSE};
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_cmd <= '0;
    in_command_code <= '0;
    in_response_code <= '0;
    in_response_seq <= '0;
    in_response_args <= '0;
    in_attention_bits <= '0;
    in_window_select <= 1'b0;
    in_access_position <= '0;
    in_access_length <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(xlate_item(1'b0, '0, '0));
    send_item(xlate_item(1'b1, '1, '1));
    send_item(issue_item());
    send_item(resp_item(CODE_ACK, 8'h00, seq_shadow, rand_args()));
    send_item(resp_item(CODE_ACK, RESP_SUCCESS, seq_shadow + 8'd1, rand_args()));
    send_item(resp_item(CODE_MBOXINFO, RESP_SUCCESS, seq_shadow, shift_args(8'hff)));
    send_item(resp_item(CODE_FLASHINFO, RESP_SUCCESS, seq_shadow, '1));
    send_item(resp_item(CODE_MBOXINFO, RESP_SUCCESS, seq_shadow, shift_args(8'd0)));
    send_item(resp_item(CODE_READWIN, RESP_SUCCESS, seq_shadow,
                        win_args(16'hffff, 16'hffff, 16'hffff)));
    send_item(xlate_item(1'b0, 32'h0000_ffff, 32'h0000_ffff));
    send_item(resp_item(CODE_MBOXINFO, RESP_SUCCESS, seq_shadow, shift_args(8'd16)));
    send_item(resp_item(CODE_READWIN, RESP_SUCCESS, seq_shadow,
                        win_args(16'h0010, 16'h0004, 16'h0002)));
    send_item(xlate_item(1'b0, 32'h0002_0000, 32'h0004_0000));
    send_item(xlate_item(1'b0, 32'h0003_0000, 32'h0004_0000));
    send_item(xlate_item(1'b0, 32'h0007_0000, 32'h0000_0010));
    send_item(xlate_item(1'b0, 32'h0001_0000, 32'h0000_0100));
    send_item(resp_item(CODE_WRITEWIN, RESP_SUCCESS, seq_shadow,
                        win_args(16'hffff, 16'hffff, 16'hffff)));
    send_item(xlate_item(1'b1, 32'hffff_0000, '1));
    send_item(xlate_item(1'b0, 32'h0002_0000, 32'h0000_0010));
    foreach (odd_codes[i]) begin
      send_item(resp_item(odd_codes[i], RESP_SUCCESS, seq_shadow, rand_args()));
    end
    send_item(attn_item(8'h41));
    send_item(xlate_item(1'b1, 32'hffff_0000, 32'h0000_0100));
    send_item(attn_item(ATTN_DAEMON_READY));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= RANDOM_ITEMS - QUIET_TAIL) || (n % 200 >= 170);
      if (n == LEGACY_SWITCH) begin
        a = rand_args();
        a[7:0] = VERSION_ONE_ID;
        a[39:8] = {16'd8, 16'd8};
        send_item(resp_item(CODE_MBOXINFO, RESP_SUCCESS, seq_shadow, a));
      end
      send_item(random_item(n > LEGACY_SWITCH));
    end
    in_push <= 1'b0;

    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.error_count == 0 && sb.reports_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
